@@ sv/ipd_pkg.sv @@
package ipd_pkg;

    // Page geometry
    localparam int PAGE_BYTES = 4096;
    localparam int ADDR_W     = $clog2(PAGE_BYTES);
    localparam int POS_W      = ADDR_W + 1;
    localparam int LEN_W      = 13;
    localparam int PROD_W     = 13;
    localparam int CNT_W      = 16;
    localparam int PROD_MUL_W = 2 * CNT_W;
    localparam int HDR_IDX_W  = 2;

    // Request opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_PUSH  = 2'd1;
    localparam logic [1:0] OP_PULL  = 2'd2;

    // Header byte positions
    localparam logic [HDR_IDX_W-1:0] HDR_COUNT_LO = 2'd0;
    localparam logic [HDR_IDX_W-1:0] HDR_COUNT_HI = 2'd1;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN_LO   = 2'd2;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN_HI   = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PATTERN,
        PH_REPLAY,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        MEM_NONE,
        MEM_WRITE,
        MEM_READ
    } mem_op_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [7:0]       byte_in;
        logic [LEN_W-1:0] page_len;
    } req_t;

    typedef struct packed {
        logic              accepted;
        logic              out_valid;
        logic [7:0]        out_byte;
        logic              done_res;
        logic [PROD_W-1:0] produced;
        logic [1:0]        status;
    } res_t;

    // Front-to-back command: store access plus the rest of the result
    typedef struct packed {
        mem_op_t           mem_op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic              accepted;
        logic              done_res;
        logic [PROD_W-1:0] produced;
        logic [1:0]        status;
    } cmd_t;

endpackage

@@ sv/ipd_front.sv @@
module ipd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  ipd_pkg::req_t req_data,
    output logic          cmd_push,
    output ipd_pkg::cmd_t cmd_data
);
    import ipd_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [HDR_IDX_W-1:0]  hdr_idx_reg, hdr_idx_next;
    logic [CNT_W-1:0]      rep_count_reg, rep_count_next;
    logic [CNT_W-1:0]      pat_len_reg, pat_len_next;
    logic [ADDR_W-1:0]     src_left_reg, src_left_next;
    logic [CNT_W-1:0]      iter_reg, iter_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [PROD_W-1:0]     produced_reg, produced_next;
    logic [1:0]            error_reg, error_next;
    logic [PROD_MUL_W-1:0] total_reg, total_next;

    logic                  fire;
    logic [ADDR_W-1:0]     src_dec;
    logic [POS_W-1:0]      pos_inc;
    logic [CNT_W-1:0]      iter_inc;
    logic [CNT_W-1:0]      len_full;
    logic [PROD_MUL_W-1:0] room;
    logic                  push_ok;
    logic                  hdr_push;
    logic                  pat_push;
    logic                  pull_ok;
    logic                  start_ok;

    assign fire     = req_valid && req_ready;
    assign src_dec  = src_left_reg - 1'b1;
    assign pos_inc  = pos_reg + 1'b1;
    assign iter_inc = iter_reg + 1'b1;
    assign len_full = {req_data.byte_in, pat_len_reg[7:0]};
    assign room     = PROD_MUL_W'(PAGE_BYTES) - PROD_MUL_W'(produced_reg);
    assign push_ok  = (req_data.op == OP_PUSH) && (src_left_reg != '0);
    assign hdr_push = push_ok && (phase_reg == PH_HEADER);
    assign pat_push = push_ok && (phase_reg == PH_PATTERN);
    assign pull_ok  = (req_data.op == OP_PULL) && (phase_reg == PH_REPLAY);
    assign start_ok = (req_data.op == OP_START)
                      && (32'(req_data.page_len) < 32'(PAGE_BYTES));

    // Next-state logic for the page sequencer
    always_comb
    begin
        phase_next     = phase_reg;
        hdr_idx_next   = hdr_idx_reg;
        rep_count_next = rep_count_reg;
        pat_len_next   = pat_len_reg;
        src_left_next  = src_left_reg;
        iter_next      = iter_reg;
        pos_next       = pos_reg;
        produced_next  = produced_reg;
        error_next     = error_reg;
        total_next     = total_reg;

        case (req_data.op)
            OP_START:
            begin
                hdr_idx_next   = '0;
                rep_count_next = '0;
                pat_len_next   = '0;
                iter_next      = '0;
                pos_next       = '0;
                produced_next  = '0;
                error_next     = ST_OK;
                if (!start_ok)
                begin
                    src_left_next = '0;
                    phase_next    = PH_DONE;
                    error_next    = ST_REJECTED;
                end
                else
                begin
                    src_left_next = req_data.page_len[ADDR_W-1:0];
                    phase_next    = (req_data.page_len == '0) ? PH_DONE : PH_HEADER;
                end
            end
            OP_PUSH:
            begin
                if (hdr_push)
                begin
                    src_left_next = src_dec;
                    hdr_idx_next  = hdr_idx_reg + 1'b1;
                    case (hdr_idx_reg)
                        HDR_COUNT_LO: rep_count_next = CNT_W'(req_data.byte_in);
                        HDR_COUNT_HI: rep_count_next = {req_data.byte_in, rep_count_reg[7:0]};
                        HDR_LEN_LO:   pat_len_next   = CNT_W'(req_data.byte_in);
                        default:      pat_len_next   = len_full;
                    endcase
                    if (hdr_idx_reg == HDR_LEN_HI)
                    begin
                        total_next = PROD_MUL_W'(rep_count_reg) * PROD_MUL_W'(len_full);
                        if (rep_count_reg == '0)
                        begin
                            phase_next = PH_DONE;
                            error_next = ST_OK;
                        end
                        else if (len_full == '0)
                        begin
                            // empty pattern: move on to the next record
                            pos_next   = '0;
                            iter_next  = '0;
                            phase_next = (src_dec == '0) ? PH_DONE : PH_HEADER;
                            if (src_dec == '0)
                                error_next = ST_OK;
                        end
                        else if (src_dec == '0)
                        begin
                            phase_next = PH_DONE;
                            error_next = ST_OK;
                        end
                        else
                        begin
                            phase_next = PH_PATTERN;
                            pos_next   = '0;
                        end
                    end
                    else if (src_dec == '0)
                    begin
                        phase_next = PH_DONE;
                        error_next = ST_OK;
                    end
                end
                else if (pat_push)
                begin
                    src_left_next = src_dec;
                    pos_next      = pos_inc;
                    if (CNT_W'(pos_inc) >= pat_len_reg)
                    begin
                        // full record in store: check room before replay
                        if (total_reg > room)
                        begin
                            phase_next = PH_DONE;
                            error_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            phase_next = PH_REPLAY;
                            pos_next   = '0;
                            iter_next  = '0;
                        end
                    end
                    else if (src_dec == '0)
                    begin
                        phase_next = PH_DONE;
                        error_next = ST_OK;
                    end
                end
            end
            OP_PULL:
            begin
                if (pull_ok)
                begin
                    produced_next = produced_reg + 1'b1;
                    pos_next      = pos_inc;
                    if (CNT_W'(pos_inc) >= pat_len_reg)
                    begin
                        pos_next  = '0;
                        iter_next = iter_inc;
                        if (iter_inc >= rep_count_reg)
                        begin
                            hdr_idx_next = '0;
                            iter_next    = '0;
                            if (src_left_reg == '0)
                            begin
                                phase_next = PH_DONE;
                                error_next = ST_OK;
                            end
                            else
                            begin
                                phase_next = PH_HEADER;
                            end
                        end
                    end
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Command and result fields for the back end
    always_comb
    begin
        cmd_push          = fire;
        cmd_data.mem_op   = MEM_NONE;
        cmd_data.addr     = pos_reg[ADDR_W-1:0];
        cmd_data.data     = req_data.byte_in;
        cmd_data.accepted = start_ok || hdr_push || pat_push;
        cmd_data.done_res = (phase_next == PH_DONE);
        cmd_data.produced = produced_next;
        cmd_data.status   = error_next;
        if (pat_push)
            cmd_data.mem_op = MEM_WRITE;
        else if (pull_ok)
            cmd_data.mem_op = MEM_READ;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            hdr_idx_reg   <= '0;
            rep_count_reg <= '0;
            pat_len_reg   <= '0;
            src_left_reg  <= '0;
            iter_reg      <= '0;
            pos_reg       <= '0;
            produced_reg  <= '0;
            error_reg     <= ST_OK;
            total_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            rep_count_reg <= rep_count_next;
            pat_len_reg   <= pat_len_next;
            src_left_reg  <= src_left_next;
            iter_reg      <= iter_next;
            pos_reg       <= pos_next;
            produced_reg  <= produced_next;
            error_reg     <= error_next;
            total_reg     <= total_next;
        end
    end

endmodule

@@ sv/ipd_queue.sv @@
module ipd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ipd_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output ipd_pkg::cmd_t head_data
);
    import ipd_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ sv/ipd_back.sv @@
module ipd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  ipd_pkg::cmd_t head_data,
    output logic          pop,
    output logic          res_valid,
    input  logic          res_ready,
    output ipd_pkg::res_t res_data
);
    import ipd_pkg::*;

    logic [7:0]        store_mem [PAGE_BYTES];
    logic              valid_reg;
    logic              accepted_reg;
    logic              rd_flag_reg;
    logic [7:0]        byte_reg;
    logic              done_reg;
    logic [PROD_W-1:0] produced_reg;
    logic [1:0]        status_reg;

    // Take the next command whenever the output register frees up
    assign pop = head_valid && (!valid_reg || res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (res_ready)
            valid_reg <= 1'b0;
    end

    // Pattern store: at most one write or one registered read per command
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            case (head_data.mem_op)
                MEM_WRITE:
                begin
                    store_mem[head_data.addr] <= head_data.data;
                    byte_reg <= '0;
                end
                MEM_READ: byte_reg <= store_mem[head_data.addr];
                default:  byte_reg <= '0;
            endcase
        end
    end

    // Result fields that ride along with the command
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            accepted_reg <= head_data.accepted;
            rd_flag_reg  <= (head_data.mem_op == MEM_READ);
            done_reg     <= head_data.done_res;
            produced_reg <= head_data.produced;
            status_reg   <= head_data.status;
        end
    end

    assign res_valid          = valid_reg;
    assign res_data.accepted  = accepted_reg;
    assign res_data.out_valid = rd_flag_reg;
    assign res_data.out_byte  = byte_reg;
    assign res_data.done_res  = done_reg;
    assign res_data.produced  = produced_reg;
    assign res_data.status    = status_reg;

endmodule

@@ sv/iterated_page_decoder_unit.sv @@
// Result path: a request is registered in the command queue, then in the output register;
// a result waits longer while earlier results wait on the result side.
// Throughput: one request per clock unless the queue is full; each yields exactly one result.
// The figure is set by the single-port pattern store, one access per request.
// A 2-entry command queue between the sequencer and the store side absorbs stalls.
// Reset clears sequencer, queue and output valid at once; the store is not cleared.
module iterated_page_decoder_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ipd_pkg::req_t req_data,
    output logic          res_valid,
    input  logic          res_ready,
    output ipd_pkg::res_t res_data
);
    import ipd_pkg::*;

    logic cmd_push;
    cmd_t cmd_data;
    logic q_full;
    logic q_pop;
    logic q_head_valid;
    cmd_t q_head;

    assign req_ready = !q_full;

    ipd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .cmd_push  (cmd_push),
        .cmd_data  (cmd_data)
    );

    ipd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_data  (cmd_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head)
    );

    ipd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_data  (q_head),
        .pop        (q_pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

endmodule

@@ sv/ipd_checker.sv @@
module ipd_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input ipd_pkg::req_t req_data,
    input logic          res_valid,
    input logic          res_ready,
    input ipd_pkg::res_t res_data
);
    import ipd_pkg::*;

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    // Request side only backs up behind a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> res_valid)
        else $error("request refused with result side empty");

    // A fresh result follows an accepted request through the command queue and output register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result without matching request");

    // A replayed byte never comes with a take or an error
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.out_valid |-> !res_data.accepted && res_data.status == ST_OK)
        else $error("replay result with bad flags");

    // A waiting request holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req_data))
        else $error("waiting request changed");

endmodule

bind iterated_page_decoder_unit ipd_checker u_ipd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);
